// File: sv/folb_pkg.sv
package folb_pkg;

    localparam int MAX_OVERLAY_COLS = 256;
    localparam int MAX_OVERLAY_ROWS = 256;
    localparam int COL_IDX_W = $clog2(MAX_OVERLAY_COLS);
    localparam int ROW_IDX_W = $clog2(MAX_OVERLAY_ROWS);
    localparam int STORE_DEPTH = MAX_OVERLAY_COLS * MAX_OVERLAY_ROWS;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // wide enough for a 12 bit frame size and for the largest overlay size
    localparam int AXIS_W = 13;

    localparam int FRAME_W = 12;
    localparam int OVL_W = 9;
    localparam int FADE_W = 16;
    localparam int PIX_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int WEIGHT_W = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [32:0] BLEND_DEN = 33'd16711680;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_PIXEL = 2'd2,
        OP_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_OVERLAY_COLS = 3'd2,
        REG_OVERLAY_ROWS = 3'd3,
        REG_FADE_IN_LEN  = 3'd4,
        REG_HOLD_LEN     = 3'd5,
        REG_FADE_OUT_LEN = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [FRAME_W-1:0] col;
        logic [FRAME_W-1:0] row;
        logic [PIX_W-1:0]   frame_luma;
        logic [PIX_W-1:0]   load_luma;
        logic [PIX_W-1:0]   load_alpha;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_luma;
        logic             covered;
        logic             showing;
    } result_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [OVL_W-1:0]   overlay_cols;
        logic [OVL_W-1:0]   overlay_rows;
    } geom_cfg_t;

    typedef struct packed {
        logic [FADE_W-1:0] fade_in_len;
        logic [FADE_W-1:0] hold_len;
        logic [FADE_W-1:0] fade_out_len;
    } fade_cfg_t;

    // classified item as it travels from the front to the back
    typedef struct packed {
        opcode_t           op;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  luma;
        logic [PIX_W-1:0]  alpha;
    } cmd_t;

    typedef struct packed {
        logic                active;
        logic [WEIGHT_W-1:0] weight;
    } back_stat_t;

endpackage

// File: sv/folb_front.sv
module folb_front (
    input  folb_pkg::item_t     item,
    input  folb_pkg::geom_cfg_t geom,
    output folb_pkg::cmd_t      cmd
);
    import folb_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [AXIS_W-1:0] rel;
    } axis_t;

    // Window offset and size along one axis, then the position check.
    function automatic axis_t axis_check(
        input logic [FRAME_W-1:0] frame_len,
        input logic [OVL_W-1:0]   ov_len,
        input logic [AXIS_W-1:0]  max_len,
        input logic [FRAME_W-1:0] pos
    );
        logic [AXIS_W-1:0] fl;
        logic [AXIS_W-1:0] ov;
        logic [AXIS_W-1:0] off;
        logic [AXIS_W-1:0] size;
        logic [AXIS_W-1:0] p;
        axis_t             r;
        fl = AXIS_W'(frame_len);
        p  = AXIS_W'(pos);
        ov = (AXIS_W'(ov_len) > max_len) ? max_len : AXIS_W'(ov_len);
        if (ov >= fl)
        begin
            off  = '0;
            size = fl;
        end
        else
        begin
            off  = (fl - ov) >> 1;
            size = ov;
        end
        r.rel = p - off;
        r.hit = (p >= off) && (r.rel < size);
        return r;
    endfunction

    axis_t h_axis;
    axis_t v_axis;
    logic  load_in_range;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] load_addr;

    assign h_axis = axis_check(geom.frame_width, geom.overlay_cols,
                               AXIS_W'(MAX_OVERLAY_COLS), item.col);
    assign v_axis = axis_check(geom.frame_height, geom.overlay_rows,
                               AXIS_W'(MAX_OVERLAY_ROWS), item.row);

    assign load_in_range = (AXIS_W'(item.col) < AXIS_W'(MAX_OVERLAY_COLS))
                        && (AXIS_W'(item.row) < AXIS_W'(MAX_OVERLAY_ROWS));

    assign pix_addr = ADDR_W'(ADDR_W'(v_axis.rel[ROW_IDX_W-1:0])
                              * ADDR_W'(MAX_OVERLAY_COLS))
                    + ADDR_W'(h_axis.rel[COL_IDX_W-1:0]);
    assign load_addr = ADDR_W'(ADDR_W'(item.row[ROW_IDX_W-1:0])
                               * ADDR_W'(MAX_OVERLAY_COLS))
                     + ADDR_W'(item.col[COL_IDX_W-1:0]);

    always_comb
    begin
        cmd.op    = item.opcode;
        cmd.alpha = item.load_alpha;
        cmd.luma  = item.frame_luma;
        cmd.addr  = pix_addr;
        cmd.hit   = 1'b0;
        unique case (item.opcode)
            OP_LOAD:
            begin
                cmd.luma = item.load_luma;
                cmd.addr = load_addr;
                cmd.hit  = load_in_range;
            end
            OP_PIXEL:
            begin
                cmd.hit = h_axis.hit && v_axis.hit;
            end
            default:
            begin
                cmd.hit = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/folb_queue.sv
module folb_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  folb_pkg::cmd_t            wdata,
    output logic                      full,
    input  logic                      pop,
    output folb_pkg::cmd_t            rdata,
    output logic                      empty,
    output logic [folb_pkg::QPTR_W:0] level
);
    import folb_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/folb_back.sv
module folb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  folb_pkg::cmd_t       cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  folb_pkg::fade_cfg_t  fade,
    output folb_pkg::result_t    result,
    output logic                 result_valid,
    input  logic                 result_ready,
    output folb_pkg::back_stat_t stat
);
    import folb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_WCALC,
        ST_DIV,
        ST_MULK,
        ST_MULP,
        ST_SUM,
        ST_SCALE,
        ST_DONE
    } state_t;

    localparam int STEP_W = $clog2(WEIGHT_W);

    // overlay store: luma in the upper byte, alpha in the lower
    logic [2*PIX_W-1:0] store_mem [STORE_DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic               mem_we;

    state_t              state_reg, state_next;
    cmd_t                cur_reg, cur_next;
    logic [31:0]         frame_count_reg, frame_count_next;
    logic [31:0]         show_start_reg, show_start_next;
    logic                active_reg, active_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [WEIGHT_W-1:0] rem_reg, rem_next;
    logic [WEIGHT_W-1:0] quo_reg, quo_next;
    logic [FADE_W-1:0]   div_reg, div_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [WEIGHT_W+PIX_W-1:0] k_reg, k_next;
    logic [PIX_W-1:0]    src_reg, src_next;
    logic signed [34:0]  prod_reg, prod_next;
    logic [16:0]         x_reg, x_next;
    logic [PIX_W-1:0]    res_luma_reg, res_luma_next;
    logic                res_cov_reg, res_cov_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [31:0]         elapsed;
    logic [16:0]         end_hold;
    logic [17:0]         end_fade;
    logic [17:0]         fade_left;
    logic                div_bit;
    logic [WEIGHT_W-1:0] rem_sub;
    logic [PIX_W:0]      luma_diff;
    logic [32:0]         dst_term;
    logic signed [35:0]  blend_num;
    logic [17:0]         scaled;

    assign elapsed   = frame_count_reg - show_start_reg;
    assign end_hold  = 17'(fade.fade_in_len) + 17'(fade.hold_len);
    assign end_fade  = 18'(end_hold) + 18'(fade.fade_out_len);
    assign fade_left = end_fade - elapsed[17:0];

    assign div_bit = (rem_reg >= WEIGHT_W'(div_reg));
    assign rem_sub = div_bit ? rem_reg - WEIGHT_W'(div_reg) : rem_reg;

    assign luma_diff = {1'b0, src_reg} - {1'b0, cur_reg.luma};
    assign dst_term  = 33'(cur_reg.luma * BLEND_DEN);
    assign blend_num = $signed({3'b000, dst_term}) + 36'(prod_reg);
    // x / 255 for x below 65536
    assign scaled    = 18'(x_reg) + 18'(x_reg[16:8]) + 18'd1;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;
    assign stat.active  = active_reg;
    assign stat.weight  = weight_reg;

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        frame_count_next = frame_count_reg;
        show_start_next  = show_start_reg;
        active_next      = active_reg;
        weight_next      = weight_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_next         = div_reg;
        step_next        = step_reg;
        k_next           = k_reg;
        src_next         = src_reg;
        prod_next        = prod_reg;
        x_next           = x_reg;
        res_luma_next    = res_luma_reg;
        res_cov_next     = res_cov_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        cmd_pop          = 1'b0;
        mem_we           = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_luma_next = '0;
                res_cov_next  = 1'b0;
                unique case (cur_reg.op)
                    OP_LOAD:
                    begin
                        mem_we     = cur_reg.hit;
                        state_next = ST_DONE;
                    end
                    OP_START:
                    begin
                        show_start_next = frame_count_reg;
                        active_next     = 1'b1;
                        state_next      = ST_WCALC;
                    end
                    OP_PIXEL:
                    begin
                        res_luma_next = cur_reg.luma;
                        // store read issued this cycle, data in the next
                        state_next = (cur_reg.hit && active_reg) ? ST_MULK : ST_DONE;
                    end
                    OP_TICK:
                    begin
                        frame_count_next = frame_count_reg + 32'd1;
                        state_next       = ST_TICK;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_TICK:
            begin
                if (!active_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (elapsed > 32'(end_fade))
                begin
                    active_next = 1'b0;
                    weight_next = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_WCALC;
                end
            end
            ST_WCALC:
            begin
                quo_next  = '0;
                step_next = '0;
                if (elapsed < 32'(fade.fade_in_len))
                begin
                    rem_next   = WEIGHT_W'(elapsed[FADE_W-1:0]);
                    div_next   = fade.fade_in_len;
                    state_next = ST_DIV;
                end
                else if (elapsed < 32'(end_hold))
                begin
                    weight_next = WEIGHT_ONE;
                    state_next  = ST_DONE;
                end
                else if (fade.fade_out_len == '0 || elapsed > 32'(end_fade))
                begin
                    weight_next = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    rem_next   = fade_left[WEIGHT_W-1:0];
                    div_next   = fade.fade_out_len;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit of (n << 16) / d per cycle, n never above d
                quo_next  = {quo_reg[WEIGHT_W-2:0], div_bit};
                rem_next  = {rem_sub[WEIGHT_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(WEIGHT_W - 1))
                begin
                    weight_next = {quo_reg[WEIGHT_W-2:0], div_bit};
                    state_next  = ST_DONE;
                end
            end
            ST_MULK:
            begin
                k_next     = (WEIGHT_W+PIX_W)'(weight_reg * rd_data_reg[PIX_W-1:0]);
                src_next   = rd_data_reg[2*PIX_W-1:PIX_W];
                state_next = ST_MULP;
            end
            ST_MULP:
            begin
                prod_next  = 35'($signed(luma_diff) * $signed({1'b0, k_reg}));
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                x_next     = blend_num[32:16];
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                res_luma_next = scaled[15:8];
                res_cov_next  = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_next.out_luma = res_luma_reg;
                    out_next.covered  = res_cov_reg;
                    out_next.showing  = active_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_reg         <= '0;
            frame_count_reg <= '0;
            show_start_reg  <= '0;
            active_reg      <= 1'b0;
            weight_reg      <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            div_reg         <= '0;
            step_reg        <= '0;
            k_reg           <= '0;
            src_reg         <= '0;
            prod_reg        <= '0;
            x_reg           <= '0;
            res_luma_reg    <= '0;
            res_cov_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            frame_count_reg <= frame_count_next;
            show_start_reg  <= show_start_next;
            active_reg      <= active_next;
            weight_reg      <= weight_next;
            rem_reg         <= rem_next;
            quo_reg         <= quo_next;
            div_reg         <= div_next;
            step_reg        <= step_next;
            k_reg           <= k_next;
            src_reg         <= src_next;
            prod_reg        <= prod_next;
            x_reg           <= x_next;
            res_luma_reg    <= res_luma_next;
            res_cov_reg     <= res_cov_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[cur_reg.addr] <= {cur_reg.luma, cur_reg.alpha};
        end
        rd_data_reg <= store_mem[cur_reg.addr];
    end

endmodule

// File: sv/faded_overlay_luma_blend.sv
// Overlay blender: load items fill a 256 x 256 store of luma/alpha pairs, a start item
// opens a fade-in / hold / fade-out schedule, tick items count frames, and frame pixel
// items come back blended (or passed through with covered low) in arrival order, one
// result per item. Items are classified on entry and held in a four-deep command queue,
// so input keeps flowing while a result waits at the output register. The execution
// unit takes one command at a time: a load or a pass-through pixel goes from execute
// straight to the result stage, a covered frame pixel adds a store read, two multiplies,
// a sum and a divide by 255, and a start or a tick runs the 17-step fade weight divider
// when the weight needs a division (a tick skips the weight step when no schedule runs
// or the schedule ends). A result held for result_ready stalls the unit. Configuration
// registers take effect on the next item; write them only while the block is idle.
module faded_overlay_luma_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  folb_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output folb_pkg::result_t                   result,
    input  logic                                cfg_write,
    input  logic [folb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [folb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import folb_pkg::*;

    geom_cfg_t       geom_reg;
    fade_cfg_t       fade_reg;
    cmd_t            front_cmd;
    cmd_t            q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic [QPTR_W:0] q_level;
    back_stat_t      stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.frame_width  <= 12'd720;
            geom_reg.frame_height <= 12'd480;
            geom_reg.overlay_cols <= 9'd256;
            geom_reg.overlay_rows <= 9'd256;
            fade_reg.fade_in_len  <= '0;
            fade_reg.hold_len     <= '0;
            fade_reg.fade_out_len <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  geom_reg.frame_width  <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: geom_reg.frame_height <= cfg_data[FRAME_W-1:0];
                REG_OVERLAY_COLS: geom_reg.overlay_cols <= cfg_data[OVL_W-1:0];
                REG_OVERLAY_ROWS: geom_reg.overlay_rows <= cfg_data[OVL_W-1:0];
                REG_FADE_IN_LEN:  fade_reg.fade_in_len  <= cfg_data;
                REG_HOLD_LEN:     fade_reg.hold_len     <= cfg_data;
                REG_FADE_OUT_LEN: fade_reg.fade_out_len <= cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign item_ready = !q_full;

    folb_front u_front (
        .item (item),
        .geom (geom_reg),
        .cmd  (front_cmd)
    );

    folb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_valid),
        .wdata (front_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_head),
        .empty (q_empty),
        .level (q_level)
    );

    folb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (q_head),
        .cmd_valid    (!q_empty),
        .cmd_pop      (q_pop),
        .fade         (fade_reg),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat)
    );

    a_cover_needs_show: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.covered |-> result.showing)
        else $error("covered pixel reported while no schedule is showing");

    a_transfer_queued: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> q_level != '0)
        else $error("accepted transfer missing from the command queue");

    a_idle_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.active |-> stat.weight == '0)
        else $error("fade weight nonzero with no active schedule");

endmodule
